FILE: rtl/cfla_pkg.sv
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and codes for the chunked free-list cell allocator.
// ----------------------------------------------------------------------------
package cfla_pkg;

    // Fixed field widths
    localparam int unsigned ID_W    = 16;
    localparam int unsigned OFS_W   = 25;
    localparam int unsigned USE_W   = 17;
    localparam int unsigned CBYTE_W = 10;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Error codes
    localparam logic [1:0] E_NONE        = 2'd0;
    localparam logic [1:0] E_NO_CHUNK    = 2'd1;
    localparam logic [1:0] E_EMPTY_CHUNK = 2'd2;

    // Cell size after reset
    localparam logic [CBYTE_W-1:0] CBYTE_RST = 10'd8;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] cell_id;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]  alloc_id;
        logic [OFS_W-1:0] byte_offset;
        logic             ok;
        logic [1:0]       error;
        logic [USE_W-1:0] cells_in_use;
    } t_out;

    // Datapath commands from the controller
    typedef enum logic [3:0] {
        C_NONE,
        C_LATCH,
        C_DIVQ,
        C_DIVR,
        C_RD,
        C_EVAL,
        C_POP,
        C_FILL,
        C_OPEN,
        C_SCAN,
        C_MUL
    } t_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic op;
        logic hit;
        logic no_empty;
        logic fill_last;
        logic scan_done;
    } t_sts;

endpackage

FILE: rtl/chunked_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// chunked_free_list_allocator_core
// Hands out and takes back fixed-size cell ids grouped in chunks, each chunk
// keeping its own linked free list.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------
//  request  | in        | i_valid / o_stall   | i_data (op, cell_id)
//  result   | out       | o_valid / i_stall   | o_data (id, offset, status)
//  config   | in        | i_cfg_we            | i_cfg_wdata (cell_bytes)
//
//  Every request is divided, read and evaluated before its result is loaded;
//  a hit allocate adds a pop step, and an allocate that opens a chunk first
//  fills its link list, opens it, and scans past live chunks for the next
//  empty one.
//  The steps follow from the registered reads of the chunk tables and link RAM.
//  The result sits in an output register; the next request runs while it
//  waits and stalls only at the point of loading a new result.
//  No clearing pass after reset: chunk tables are masked by live bits.
// ----------------------------------------------------------------------------
module chunked_free_list_allocator_core
    import cfla_pkg::*;
#(
    parameter int unsigned CELLS_PER_CHUNK = 256,
    parameter int unsigned NUM_CHUNKS      = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in                i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out               o_data,
    input  logic               i_cfg_we,
    input  logic [CBYTE_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    cfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    cfla_dp #(
        .CELLS_PER_CHUNK (CELLS_PER_CHUNK),
        .NUM_CHUNKS      (NUM_CHUNKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_data      (o_data)
    );

    // A result that reports success carries no error code
    a_ok_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.ok == (o_data.error == E_NONE)))
        else $error("ok and error disagree");

    // A failed operation hands out no id and no offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |-> (o_data.alloc_id == '0 && o_data.byte_offset == '0))
        else $error("failed operation returned an id");

    // Live cell count never exceeds the pool
    a_use_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.cells_in_use <= USE_W'(NUM_CHUNKS * CELLS_PER_CHUNK)))
        else $error("cells in use beyond pool size");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

FILE: rtl/cfla_ram.sv
// ----------------------------------------------------------------------------
// cfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cfla_ctrl.sv
// ----------------------------------------------------------------------------
// cfla_ctrl
// Sequencer for the allocator: steps the datapath through one request and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module cfla_ctrl
    import cfla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVQ,
        S_DIVR,
        S_RD,
        S_EVAL,
        S_POP,
        S_FILL,
        S_OPEN,
        S_SCAN,
        S_MUL
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // Command decode and next state
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = C_NONE;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = C_LATCH;
                    n_state = S_DIVQ;
                end
            end
            S_DIVQ: begin
                o_cmd   = C_DIVQ;
                n_state = S_DIVR;
            end
            S_DIVR: begin
                o_cmd   = C_DIVR;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd   = C_RD;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd = C_EVAL;
                if (i_sts.op == OP_FREE || i_sts.no_empty) begin
                    n_state = S_MUL;
                end else if (i_sts.hit) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_POP: begin
                o_cmd   = C_POP;
                n_state = S_MUL;
            end
            S_FILL: begin
                o_cmd = C_FILL;
                if (i_sts.fill_last) begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                o_cmd   = C_OPEN;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd = C_SCAN;
                if (i_sts.scan_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Load the output register once the previous result has gone
                if (!r_ovalid) begin
                    o_cmd    = C_MUL;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

FILE: rtl/cfla_dp.sv
// ----------------------------------------------------------------------------
// cfla_dp
// Allocator datapath: chunk tables, link memory, counters, id split and
// output register.
// ----------------------------------------------------------------------------
module cfla_dp
    import cfla_pkg::*;
#(
    parameter int unsigned CELLS_PER_CHUNK = 256,
    parameter int unsigned NUM_CHUNKS      = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CBYTE_W-1:0] i_cfg_wdata,
    input  t_in                i_data,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output t_out               o_data
);

    localparam int unsigned CW    = $clog2(CELLS_PER_CHUNK);
    localparam int unsigned HW    = $clog2(CELLS_PER_CHUNK + 1);
    localparam int unsigned KW    = $clog2(NUM_CHUNKS);
    localparam int unsigned EW    = $clog2(NUM_CHUNKS + 1);
    localparam int unsigned AW    = $clog2(NUM_CHUNKS * CELLS_PER_CHUNK);
    localparam int unsigned RSH   = 28;
    localparam int unsigned RECIP = (1 << RSH) / CELLS_PER_CHUNK;
    localparam int unsigned PW    = ID_W + RSH;
    localparam logic [HW-1:0] LIST_END = HW'(CELLS_PER_CHUNK);

    // Registers
    logic [CBYTE_W-1:0]    r_cbytes;
    logic                  r_op;
    logic [ID_W-1:0]       r_id;
    logic [ID_W-1:0]       r_q;
    logic [ID_W-1:0]       r_c;
    logic [CW-1:0]         r_k;
    logic [NUM_CHUNKS-1:0] r_live;
    logic [KW-1:0]         r_pref;
    logic [EW-1:0]         r_next_empty;
    logic [USE_W-1:0]      r_live_total;
    logic [CW-1:0]         r_fill;
    logic [EW-1:0]         r_scan;
    logic [ID_W-1:0]       r_res_id;
    logic                  r_res_ok;
    logic [1:0]            r_res_err;
    t_out                  r_out;

    // RAM ports
    logic          head_we, cnt_we, link_we;
    logic [KW-1:0] tbl_addr;
    logic [HW-1:0] head_wd, cnt_wd, link_wd;
    logic [HW-1:0] head_q, cnta_q, cntb_q, link_q;
    logic [KW-1:0] lnk_chunk;
    logic [CW-1:0] lnk_cell;
    logic [AW-1:0] link_addr;

    // Decoded values
    logic [31:0]   rem;
    logic          c_ok, live_sel, live_p;
    logic [HW-1:0] head_g, cnt_g, cntb_g;
    logic [KW-1:0] e_chunk;
    logic          scan_done;

    assign e_chunk = r_next_empty[KW-1:0];
    assign c_ok    = (r_c < ID_W'(NUM_CHUNKS));
    assign live_p  = r_live[r_pref];

    // Table address: chunk of the freed cell, chunk being opened, or preferred
    always_comb begin
        if (r_op == OP_FREE) begin
            tbl_addr = r_c[KW-1:0];
        end else if (i_cmd == C_OPEN) begin
            tbl_addr = e_chunk;
        end else begin
            tbl_addr = r_pref;
        end
    end

    assign live_sel = (r_op == OP_FREE) ? (c_ok && r_live[r_c[KW-1:0]]) : live_p;
    assign head_g   = live_sel ? head_q : LIST_END;
    assign cnt_g    = live_sel ? cnta_q : '0;
    assign cntb_g   = live_p ? cntb_q : '0;

    // Link memory address: fill sweep, freed cell, or head of preferred chunk
    always_comb begin
        if (i_cmd == C_FILL) begin
            lnk_chunk = e_chunk;
            lnk_cell  = r_fill;
        end else if (r_op == OP_FREE) begin
            lnk_chunk = r_c[KW-1:0];
            lnk_cell  = r_k;
        end else begin
            lnk_chunk = r_pref;
            lnk_cell  = head_q[CW-1:0];
        end
    end
    assign link_addr = AW'(lnk_chunk) * AW'(CELLS_PER_CHUNK) + AW'(lnk_cell);

    // Remainder of the reciprocal division, one correction at most
    assign rem = 32'(r_id) - 32'(r_q) * 32'(CELLS_PER_CHUNK);

    assign scan_done = (r_scan >= EW'(NUM_CHUNKS)) || !r_live[r_scan[KW-1:0]];

    // Write enables and data for the tables
    always_comb begin
        head_we = 1'b0;
        cnt_we  = 1'b0;
        link_we = 1'b0;
        head_wd = '0;
        cnt_wd  = '0;
        link_wd = '0;
        case (i_cmd)
            C_EVAL: begin
                if (r_op == OP_FREE && live_sel && cnt_g != '0) begin
                    head_we = 1'b1;
                    cnt_we  = 1'b1;
                    if (cnt_g == HW'(1)) begin
                        head_wd = LIST_END;
                        cnt_wd  = '0;
                    end else begin
                        head_wd = HW'(r_k);
                        cnt_wd  = cnt_g - HW'(1);
                        link_we = 1'b1;
                        link_wd = head_g;
                    end
                end
            end
            C_POP: begin
                head_we = 1'b1;
                cnt_we  = 1'b1;
                head_wd = link_q;
                cnt_wd  = cnt_g + HW'(1);
            end
            C_FILL: begin
                link_we = 1'b1;
                link_wd = HW'(r_fill) + HW'(1);
            end
            C_OPEN: begin
                head_we = 1'b1;
                cnt_we  = 1'b1;
                head_wd = HW'(1);
                cnt_wd  = HW'(1);
            end
            default: begin
            end
        endcase
    end

    cfla_ram #(.WIDTH(HW), .DEPTH(NUM_CHUNKS)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (tbl_addr),
        .i_wdata (head_wd),
        .i_raddr (tbl_addr),
        .o_rdata (head_q)
    );

    cfla_ram #(.WIDTH(HW), .DEPTH(NUM_CHUNKS)) u_cnta (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (tbl_addr),
        .i_wdata (cnt_wd),
        .i_raddr (tbl_addr),
        .o_rdata (cnta_q)
    );

    // Copy of the counts, read at the preferred chunk
    cfla_ram #(.WIDTH(HW), .DEPTH(NUM_CHUNKS)) u_cntb (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (tbl_addr),
        .i_wdata (cnt_wd),
        .i_raddr (r_pref),
        .o_rdata (cntb_q)
    );

    cfla_ram #(.WIDTH(HW), .DEPTH(NUM_CHUNKS * CELLS_PER_CHUNK)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_addr),
        .i_wdata (link_wd),
        .i_raddr (link_addr),
        .o_rdata (link_q)
    );

    // Control state of the allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbytes     <= CBYTE_RST;
            r_live       <= '0;
            r_pref       <= '0;
            r_next_empty <= '0;
            r_live_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cbytes <= i_cfg_wdata;
            end
            case (i_cmd)
                C_EVAL: begin
                    if (r_op == OP_FREE && live_sel && cnt_g != '0) begin
                        if (r_live_total != '0) begin
                            r_live_total <= r_live_total - USE_W'(1);
                        end
                        if (cnt_g == HW'(1)) begin
                            r_live[r_c[KW-1:0]] <= 1'b0;
                            if (r_next_empty > EW'(r_c[KW-1:0])) begin
                                r_next_empty <= EW'(r_c[KW-1:0]);
                            end
                        end else if (cnt_g > cntb_g) begin
                            r_pref <= r_c[KW-1:0];
                        end
                    end
                end
                C_POP: begin
                    r_live_total <= r_live_total + USE_W'(1);
                end
                C_OPEN: begin
                    r_live[e_chunk] <= 1'b1;
                    r_pref          <= e_chunk;
                    r_live_total    <= r_live_total + USE_W'(1);
                end
                C_SCAN: begin
                    if (scan_done) begin
                        r_next_empty <= r_scan;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LATCH: begin
                r_op <= i_data.op;
                r_id <= i_data.cell_id;
            end
            C_DIVQ: begin
                r_q <= ID_W'((PW'(r_id) * PW'(RECIP)) >> RSH);
            end
            C_DIVR: begin
                if (rem >= 32'(CELLS_PER_CHUNK)) begin
                    r_c <= r_q + ID_W'(1);
                    r_k <= CW'(rem - 32'(CELLS_PER_CHUNK));
                end else begin
                    r_c <= r_q;
                    r_k <= CW'(rem);
                end
            end
            C_EVAL: begin
                r_res_id  <= '0;
                r_res_ok  <= 1'b1;
                r_res_err <= E_NONE;
                r_fill    <= '0;
                if (r_op == OP_FREE) begin
                    if (!(live_sel && cnt_g != '0)) begin
                        r_res_ok  <= 1'b0;
                        r_res_err <= E_EMPTY_CHUNK;
                    end
                end else if (o_sts.no_empty) begin
                    r_res_ok  <= 1'b0;
                    r_res_err <= E_NO_CHUNK;
                end
            end
            C_POP: begin
                r_res_id <= ID_W'(AW'(r_pref) * AW'(CELLS_PER_CHUNK) + AW'(head_q[CW-1:0]));
            end
            C_FILL: begin
                r_fill <= r_fill + CW'(1);
            end
            C_OPEN: begin
                r_res_id <= ID_W'(AW'(e_chunk) * AW'(CELLS_PER_CHUNK));
                r_scan   <= r_next_empty + EW'(1);
            end
            C_SCAN: begin
                if (!scan_done) begin
                    r_scan <= r_scan + EW'(1);
                end
            end
            C_MUL: begin
                r_out.alloc_id     <= r_res_id;
                r_out.byte_offset  <= OFS_W'(r_res_id * r_cbytes);
                r_out.ok           <= r_res_ok;
                r_out.error        <= r_res_err;
                r_out.cells_in_use <= r_live_total;
            end
            default: begin
            end
        endcase
    end

    // Status to the controller
    assign o_sts.op        = r_op;
    assign o_sts.hit       = live_p && (head_q < LIST_END);
    assign o_sts.no_empty  = !(live_p && (head_q < LIST_END))
                             && (r_next_empty >= EW'(NUM_CHUNKS));
    assign o_sts.fill_last = (r_fill == CW'(CELLS_PER_CHUNK - 1));
    assign o_sts.scan_done = scan_done;

    assign o_data = r_out;

endmodule
